// ===== sv/md5_pkg.sv =====
// Shared constants, types and helper functions for the MD5 digest block.
`default_nettype none

package md5_pkg;

   typedef logic [31:0] word_type;

   localparam int BLK_WORDS = 16;

   localparam word_type CHAIN_INIT [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam word_type ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_S [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Index of the message word that a given round consumes.
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] lo;
      logic [3:0] idx;
      lo = rnd[3:0];
      unique case (rnd[5:4])
         2'd0: idx = lo;
         2'd1: idx = lo + {lo[1:0], 2'b00} + 4'd1;
         2'd2: idx = lo + {lo[2:0], 1'b0} + 4'd5;
         default: idx = {lo[0], 3'b000} - lo;
      endcase
      return idx;
   endfunction

   function automatic word_type round_func(input logic [1:0] phase, input word_type b,
                                           input word_type c, input word_type d);
      word_type f;
      unique case (phase)
         2'd0: f = (b & c) | (~b & d);
         2'd1: f = (b & d) | (c & ~d);
         2'd2: f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

   function automatic word_type rotl(input word_type x, input logic [4:0] s);
      logic [63:0] dbl;
      dbl = {x, x} << s;
      return dbl[63:32];
   endfunction

endpackage

`default_nettype wire

// ===== sv/md5_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module md5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/md5_message_digest_top.sv =====
// Top level of the MD5 digest block: byte intake, padding, round sequencer and digest output.
//
//   channel | direction | words                   | payload
//   req_    | in        | one per message byte    | data_byte, byte_present, end_message
//   rsp_    | out       | four per message        | digest_word, word_index, last_word
//
// A word without an end mark is accepted in ST_IDLE; when it completes a 64-byte block the
// compression follows (two fetch steps, 64 rounds on the shared round adder, one chaining add)
// and no new byte is taken until it ends. An end word adds a padding pass of up to 16 words
// and a compression pass, twice when the length does not fit, and then the four digest words
// wait for rsp_ready.
// Reset restores the initial chaining words and a zero byte count; req_ready is low through
// every padding and compression pass, and after an end word until the last digest word is taken.
`default_nettype none

module md5_message_digest_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_byte_present,
   input  wire logic              req_end_message,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output md5_pkg::word_type      rsp_digest_word,
   output logic [1:0]             rsp_word_index,
   output logic                   rsp_last_word
);
   import md5_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP0, ST_PREP1, ST_ROUND, ST_ADD, ST_PAD, ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [60:0] cnt_ff, cnt_in;
   word_type    acc_ff, acc_in;
   word_type    ch_ff [4];
   word_type    ch_in [4];
   word_type    a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   word_type    kw_ff, kw_in;
   logic [5:0]  rd_ff, rd_in;
   logic [3:0]  wp_ff, wp_in;
   logic        pad_pend_ff, pad_pend_in;
   logic        len_blk_ff, len_blk_in;
   logic        fin_ff, fin_in;
   logic        padding_ff, padding_in;
   logic [1:0]  idx_ff, idx_in;

   logic        ram_we;
   logic [3:0]  ram_waddr;
   word_type    ram_wdata;
   logic [3:0]  ram_raddr;
   word_type    ram_rdata;

   logic        req_take;
   logic        rsp_take;
   logic [60:0] cnt_inc;
   word_type    word_with;
   word_type    pad_word;
   logic [63:0] bit_len;
   word_type    round_sum;
   word_type    round_rot;
   logic [5:0]  rd_next;
   logic [5:0]  rd_next2;
   logic [1:0]  lane;

   md5_ram #(
      .WIDTH (32),
      .DEPTH (BLK_WORDS)
   ) u_blk_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = ch_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 2'd3);

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign cnt_inc  = cnt_ff + 61'd1;
   assign lane     = cnt_ff[1:0];
   assign bit_len  = {cnt_ff, 3'b000};
   assign rd_next  = rd_ff + 6'd1;
   assign rd_next2 = rd_ff + 6'd2;

   assign round_sum = a_ff + round_func(rd_ff[5:4], b_ff, c_ff, d_ff) + kw_ff;
   assign round_rot = rotl(round_sum, ROT_S[{rd_ff[5:4], rd_ff[1:0]}]);

   always_comb begin
      word_with = acc_ff;
      word_with[8*lane +: 8] = req_data_byte;
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (2'(k) < lane) begin
            pad_word[8*k +: 8] = acc_ff[8*k +: 8];
         end else if (2'(k) == lane) begin
            pad_word[8*k +: 8] = 8'h80;
         end else begin
            pad_word[8*k +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      ch_in       = ch_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      d_in        = d_ff;
      kw_in       = kw_ff;
      rd_in       = rd_ff;
      wp_in       = wp_ff;
      pad_pend_in = pad_pend_ff;
      len_blk_in  = len_blk_ff;
      fin_in      = fin_ff;
      padding_in  = padding_ff;
      idx_in      = idx_ff;
      ram_we      = 1'b0;
      ram_waddr   = cnt_ff[5:2];
      ram_wdata   = word_with;
      ram_raddr   = msg_index(6'd0);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_byte_present) begin
                  cnt_in = cnt_inc;
                  acc_in = word_with;
                  ram_we = (lane == 2'd3);
                  if (cnt_ff[5:0] == 6'd63) begin
                     fin_in   = req_end_message;
                     state_in = ST_PREP0;
                  end else if (req_end_message) begin
                     fin_in      = 1'b1;
                     padding_in  = 1'b1;
                     pad_pend_in = 1'b1;
                     wp_in       = cnt_inc[5:2];
                     len_blk_in  = (cnt_inc[5:2] < 4'd14);
                     state_in    = ST_PAD;
                  end
               end else if (req_end_message) begin
                  fin_in      = 1'b1;
                  padding_in  = 1'b1;
                  pad_pend_in = 1'b1;
                  wp_in       = cnt_ff[5:2];
                  len_blk_in  = (cnt_ff[5:2] < 4'd14);
                  state_in    = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ram_we    = 1'b1;
            ram_waddr = wp_ff;
            if (pad_pend_ff) begin
               ram_wdata   = pad_word;
               pad_pend_in = 1'b0;
            end else if (len_blk_ff && wp_ff == 4'd14) begin
               ram_wdata = bit_len[31:0];
            end else if (len_blk_ff && wp_ff == 4'd15) begin
               ram_wdata = bit_len[63:32];
            end else begin
               ram_wdata = '0;
            end
            wp_in = wp_ff + 4'd1;
            if (wp_ff == 4'd15) begin
               state_in = ST_PREP0;
            end
         end
         ST_PREP0: begin
            a_in      = ch_ff[0];
            b_in      = ch_ff[1];
            c_in      = ch_ff[2];
            d_in      = ch_ff[3];
            ram_raddr = msg_index(6'd0);
            state_in  = ST_PREP1;
         end
         ST_PREP1: begin
            kw_in     = ROUND_K[0] + ram_rdata;
            ram_raddr = msg_index(6'd1);
            rd_in     = 6'd0;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            a_in      = d_ff;
            d_in      = c_ff;
            c_in      = b_ff;
            b_in      = b_ff + round_rot;
            kw_in     = ROUND_K[rd_next] + ram_rdata;
            ram_raddr = msg_index(rd_next2);
            rd_in     = rd_next;
            if (rd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            ch_in[0] = ch_ff[0] + a_ff;
            ch_in[1] = ch_ff[1] + b_ff;
            ch_in[2] = ch_ff[2] + c_ff;
            ch_in[3] = ch_ff[3] + d_ff;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (!padding_ff) begin
               padding_in  = 1'b1;
               pad_pend_in = 1'b1;
               wp_in       = cnt_ff[5:2];
               len_blk_in  = (cnt_ff[5:2] < 4'd14);
               state_in    = ST_PAD;
            end else if (!len_blk_ff) begin
               pad_pend_in = 1'b0;
               wp_in       = 4'd0;
               len_blk_in  = 1'b1;
               state_in    = ST_PAD;
            end else begin
               idx_in   = 2'd0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_take) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  ch_in      = CHAIN_INIT;
                  cnt_in     = '0;
                  fin_in     = 1'b0;
                  padding_in = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         ch_ff      <= CHAIN_INIT;
         fin_ff     <= 1'b0;
         padding_ff <= 1'b0;
         idx_ff     <= 2'd0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         ch_ff      <= ch_in;
         fin_ff     <= fin_in;
         padding_ff <= padding_in;
         idx_ff     <= idx_in;
      end
      acc_ff      <= acc_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      kw_ff       <= kw_in;
      rd_ff       <= rd_in;
      wp_ff       <= wp_in;
      pad_pend_ff <= pad_pend_in;
      len_blk_ff  <= len_blk_in;
   end

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and output handshakes open at the same time");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last_word) |=> (cnt_ff == '0 && ch_ff[0] == CHAIN_INIT[0] && req_ready))
      else $error("chaining state not restored after the last digest word");

   a_round_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rd_ff != 6'd63) |=> (state_ff == ST_ROUND
                                                   && rd_ff == $past(rd_ff) + 6'd1))
      else $error("round counter skipped");

   a_no_write_in_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND || state_ff == ST_PREP1) |-> !ram_we)
      else $error("block store written during compression");
`endif

endmodule

`default_nettype wire
